// ----- src/htbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package htbc_pkg;

  // Torus side of the tile world
  localparam int TILE_EXTENT = 1024;

  localparam logic [15:0] IMMEDIATE_LIMIT_RESET = 16'd9;
  localparam logic [15:0] NEAR_LIMIT_RESET      = 16'd64;
  localparam logic [7:0]  AHEAD_RADIUS_RESET    = 8'd45;
  localparam logic [7:0]  LATERAL_RADIUS_RESET  = 8'd24;

  // Configuration register indexes
  localparam logic [1:0] CFG_IMMEDIATE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_NEAR_LIMIT      = 2'd1;
  localparam logic [1:0] CFG_AHEAD_RADIUS    = 2'd2;
  localparam logic [1:0] CFG_LATERAL_RADIUS  = 2'd3;

  // Band codes
  localparam logic [1:0] BAND_IMMEDIATE   = 2'd0;
  localparam logic [1:0] BAND_NEAR        = 2'd1;
  localparam logic [1:0] BAND_DIRECTIONAL = 2'd2;
  localparam logic [1:0] BAND_BACKGROUND  = 2'd3;

  // Sector boundaries at 11.25, 33.75, 56.25, 78.75 degrees, scaled by 2^30
  localparam logic [30:0] BOUND_COS [4] = '{
    31'd1053110176, 31'd892783698, 31'd596538995, 31'd209476638
  };
  localparam logic [30:0] BOUND_SIN [4] = '{
    31'd209476638, 31'd596538995, 31'd892783698, 31'd1053110176
  };

  // Rounded 127*cos and 127*sin of each sector angle
  localparam logic signed [7:0] TABLE_HX [16] = '{
    8'sd127, 8'sd117, 8'sd90, 8'sd49, 8'sd0, -8'sd49, -8'sd90, -8'sd117,
    -8'sd127, -8'sd117, -8'sd90, -8'sd49, 8'sd0, 8'sd49, 8'sd90, 8'sd117
  };
  localparam logic signed [7:0] TABLE_HY [16] = '{
    8'sd0, 8'sd49, 8'sd90, 8'sd117, 8'sd127, 8'sd117, 8'sd90, 8'sd49,
    8'sd0, -8'sd49, -8'sd90, -8'sd117, -8'sd127, -8'sd117, -8'sd90, -8'sd49
  };

  // Per-item fields that travel down the pipeline beside the arithmetic
  typedef struct packed {
    logic [10:0] offset_x;
    logic [10:0] offset_y;
    logic [3:0]  sector;
    logic [1:0]  band;
    logic        dir;
  } meta_t;

endpackage

`default_nettype wire

// ----- src/heading_tile_band_classifier_top.sv -----
// Heading tile band classifier.
// Input stream s_*: one tile query per request. s_tdata carries, from bit 0
// up, center_x, center_y, aim_x, aim_y, tile_x, tile_y (56 bits).
// Output stream m_*: one result per query, in order. m_tdata carries, from
// bit 0 up, band, offset_x, offset_y, sector, then four zero bits.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 immediate
// limit, 1 near limit, 2 ahead radius, 3 lateral radius); write only while
// no query is in flight.
// A query accepted into stage 1 shows on m_tvalid once it reaches stage 7.
// Throughput: one query per cycle while m_tready is high; the 7-stage
// pipeline takes a request in every cycle unless stalled; each stage holds
// at most one multiply level of the sector, distance and ellipse product
// tests. Reset (rst, synchronous) empties the pipeline and restores the
// register defaults 9, 64, 45 and 24.
// When the receiver stalls, the result at the output holds and the stages
// behind it keep filling any empty slots; s_tready drops only once every
// stage holds a query.
`timescale 1ns / 1ps
`default_nettype none

module heading_tile_band_classifier_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // center_x[9:0], center_y[19:10], aim_x[27:20], aim_y[35:28],
  // tile_x[45:36], tile_y[55:46]
  input  wire logic [55:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // band[1:0], offset_x[12:2], offset_y[23:13], sector[27:24], zero[31:28]
  output logic [31:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int NS = 7;

  logic [15:0] immediate_limit_sq;
  logic [15:0] near_limit_sq;
  logic [7:0]  ahead_radius;
  logic [7:0]  lateral_radius;

  logic [NS-1:0] v;
  logic [NS-1:0] en;
  htbc_pkg::meta_t meta [NS];
  htbc_pkg::meta_t meta0_next, meta1_next, meta2_next, meta6_next;

  // stage 1
  logic signed [11:0] dx_c, dy_c;
  logic signed [7:0]  rhx_c, rhy_c;
  logic [7:0]         ax_c, ay_c;
  logic [7:0]         ax_s1, ay_s1;
  logic               hx_neg_s1, hy_neg_s1;
  // stage 2
  logic [2:0]         qcnt_c;
  logic [3:0]         sector_c;
  logic signed [20:0] xw_c, yw_c;
  logic [19:0]        dist_c, dist_s2;
  // stage 3
  logic signed [19:0] xe_c, ye_c, hxe_c, hye_c;
  logic signed [19:0] p_c, crs_c, p_s3, crs_s3;
  // stage 4
  logic [16:0]        ap_c, aq_c;
  logic [7:0]         big_r_c;
  logic signed [15:0] hx16_c, hy16_c;
  logic [24:0]        apr_s4, aqr_s4;
  logic [15:0]        k_s4;
  logic [13:0]        lsq_s4;
  // stage 5
  logic [49:0]        apr2_s5, aqr2_s5;
  logic [31:0]        k2_s5;
  logic [13:0]        lsq_s5;
  // stage 6
  logic [50:0]        lhs_s6;
  logic [45:0]        rhs_s6;

  function automatic logic signed [11:0] wrap_disp(input logic [9:0] from_v,
                                                   input logic [9:0] to_v);
    logic signed [11:0] d;
    d = $signed({2'b00, to_v}) - $signed({2'b00, from_v});
    if (d > 12'(htbc_pkg::TILE_EXTENT / 2)) begin
      d = d - 12'(htbc_pkg::TILE_EXTENT);
    end else if (d < -12'(htbc_pkg::TILE_EXTENT / 2)) begin
      d = d + 12'(htbc_pkg::TILE_EXTENT);
    end
    return d;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      immediate_limit_sq <= htbc_pkg::IMMEDIATE_LIMIT_RESET;
      near_limit_sq      <= htbc_pkg::NEAR_LIMIT_RESET;
      ahead_radius       <= htbc_pkg::AHEAD_RADIUS_RESET;
      lateral_radius     <= htbc_pkg::LATERAL_RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        htbc_pkg::CFG_IMMEDIATE_LIMIT: immediate_limit_sq <= cfg_wdata;
        htbc_pkg::CFG_NEAR_LIMIT:      near_limit_sq      <= cfg_wdata;
        htbc_pkg::CFG_AHEAD_RADIUS:    ahead_radius       <= cfg_wdata[7:0];
        htbc_pkg::CFG_LATERAL_RADIUS:  lateral_radius     <= cfg_wdata[7:0];
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when the stage after it moves
  always_comb begin
    en[NS-1] = !v[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NS-1];
  assign m_tdata  = {4'b0000, meta[NS-1].sector, meta[NS-1].offset_y,
                     meta[NS-1].offset_x, meta[NS-1].band};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage 1: wrap displacements, fix the zero heading, take magnitudes
  always_comb begin
    dx_c  = wrap_disp(s_tdata[9:0], s_tdata[45:36]);
    dy_c  = wrap_disp(s_tdata[19:10], s_tdata[55:46]);
    rhx_c = $signed(s_tdata[27:20]);
    rhy_c = $signed(s_tdata[35:28]);
    if (rhx_c == 8'sd0 && rhy_c == 8'sd0) begin
      rhy_c = 8'sd127;
    end
    ax_c = rhx_c[7] ? 8'(~rhx_c + 8'sd1) : 8'(rhx_c);
    ay_c = rhy_c[7] ? 8'(~rhy_c + 8'sd1) : 8'(rhy_c);
    meta0_next          = '0;
    meta0_next.offset_x = dx_c[10:0];
    meta0_next.offset_y = dy_c[10:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      meta[0]   <= meta0_next;
      ax_s1     <= ax_c;
      ay_s1     <= ay_c;
      hx_neg_s1 <= rhx_c[7];
      hy_neg_s1 <= rhy_c[7];
    end
  end

  // Stage 2: sector by boundary cross products, squared distance
  always_comb begin
    qcnt_c = 3'd0;
    for (int j = 0; j < 4; j++) begin
      if (39'(htbc_pkg::BOUND_COS[j]) * 39'(ay_s1) >
          39'(htbc_pkg::BOUND_SIN[j]) * 39'(ax_s1)) begin
        qcnt_c = qcnt_c + 3'd1;
      end
    end
    if (!hy_neg_s1) begin
      sector_c = hx_neg_s1 ? 4'(4'd8 - 4'(qcnt_c)) : 4'(qcnt_c);
    end else begin
      sector_c = hx_neg_s1 ? 4'(4'd8 + 4'(qcnt_c)) : 4'(5'd16 - 5'(qcnt_c));
    end
    xw_c   = 21'($signed(meta[0].offset_x));
    yw_c   = 21'($signed(meta[0].offset_y));
    dist_c = 20'(xw_c * xw_c + yw_c * yw_c);
    meta1_next        = meta[0];
    meta1_next.sector = sector_c;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      meta[1] <= meta1_next;
      dist_s2 <= dist_c;
    end
  end

  // Stage 3: distance bands, projections onto the table heading
  always_comb begin
    xe_c  = 20'($signed(meta[1].offset_x));
    ye_c  = 20'($signed(meta[1].offset_y));
    hxe_c = 20'(htbc_pkg::TABLE_HX[meta[1].sector]);
    hye_c = 20'(htbc_pkg::TABLE_HY[meta[1].sector]);
    p_c   = xe_c * hxe_c + ye_c * hye_c;
    crs_c = ye_c * hxe_c - xe_c * hye_c;
    meta2_next = meta[1];
    meta2_next.dir = 1'b0;
    if (dist_s2 <= 20'(immediate_limit_sq)) begin
      meta2_next.band = htbc_pkg::BAND_IMMEDIATE;
    end else if (dist_s2 <= 20'(near_limit_sq)) begin
      meta2_next.band = htbc_pkg::BAND_NEAR;
    end else begin
      meta2_next.band = htbc_pkg::BAND_DIRECTIONAL;
      meta2_next.dir  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      meta[2] <= meta2_next;
      p_s3    <= p_c;
      crs_s3  <= crs_c;
    end
  end

  // Stage 4: scale magnitudes by the radii, heading length squared
  always_comb begin
    ap_c    = p_s3[19] ? 17'(-p_s3) : 17'(p_s3);
    aq_c    = crs_s3[19] ? 17'(-crs_s3) : 17'(crs_s3);
    big_r_c = p_s3[19] ? lateral_radius : ahead_radius;
    hx16_c  = 16'(htbc_pkg::TABLE_HX[meta[2].sector]);
    hy16_c  = 16'(htbc_pkg::TABLE_HY[meta[2].sector]);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      apr_s4 <= 25'(ap_c) * 25'(lateral_radius);
      aqr_s4 <= 25'(aq_c) * 25'(big_r_c);
      k_s4   <= 16'(big_r_c) * 16'(lateral_radius);
      lsq_s4 <= 14'(hx16_c * hx16_c + hy16_c * hy16_c);
    end
  end

  // Stage 5: squares
  always_ff @(posedge clk) begin
    if (en[4]) begin
      apr2_s5 <= 50'(apr_s4) * 50'(apr_s4);
      aqr2_s5 <= 50'(aqr_s4) * 50'(aqr_s4);
      k2_s5   <= 32'(k_s4) * 32'(k_s4);
      lsq_s5  <= lsq_s4;
    end
  end

  // Stage 6: both sides of the ellipse inequality
  always_ff @(posedge clk) begin
    if (en[5]) begin
      lhs_s6 <= 51'(apr2_s5) + 51'(aqr2_s5);
      rhs_s6 <= 46'(lsq_s5) * 46'(k2_s5);
    end
  end

  // Stage 7: final band
  always_comb begin
    meta6_next = meta[5];
    if (meta[5].dir) begin
      meta6_next.band = (lhs_s6 <= 51'(rhs_s6)) ? htbc_pkg::BAND_DIRECTIONAL
                                                : htbc_pkg::BAND_BACKGROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      meta[3] <= meta[2];
    end
    if (en[4]) begin
      meta[4] <= meta[3];
    end
    if (en[5]) begin
      meta[5] <= meta[4];
    end
    if (en[NS-1]) begin
      meta[NS-1] <= meta6_next;
    end
  end

  // Items are neither created nor lost while nothing enters or leaves
  a_count_kept: assert property (@(posedge clk) disable iff (rst)
    (!(s_tvalid && s_tready) && !(m_tvalid && m_tready))
      |=> ($countones(v) == $past($countones(v))))
    else $error("pipeline occupancy changed without a request");

  // A stalled result holds its fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (v[NS-1] && !m_tready) |=> (v[NS-1] && $stable(meta[NS-1])))
    else $error("output result changed during stall");

  // Wrapped offsets stay within half the torus side
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (($signed(meta[NS-1].offset_x) >= -11'sd512) &&
                  ($signed(meta[NS-1].offset_x) <= 11'sd512) &&
                  ($signed(meta[NS-1].offset_y) >= -11'sd512) &&
                  ($signed(meta[NS-1].offset_y) <= 11'sd512)))
    else $error("offset outside wrap range");

endmodule

`default_nettype wire
